// ===== src/bcomp_pkg.sv =====
// Shared types and constants for the barometric compensation core.
// No dependencies; used by barometric_compensation_core and bcomp_div.
package bcomp_pkg;

	localparam int TFineOffset = 128000;
	localparam int RawPresOffset = 1048576;
	localparam logic signed [63:0] Bias47 = 64'sd1 <<< 47;
	localparam logic [24:0] PresMax = 25'h1FFFFFF;
	localparam int DivSteps = 64;
	localparam int DenW = 31;

	typedef enum logic [1:0] {
		CfgTempCal,
		CfgPresCalLow,
		CfgPresCalHigh,
		CfgPresCalLast
	} cfg_index_t;

	typedef struct packed {
		logic signed [15:0] temperature;
		logic zero;
	} side_t;

endpackage

// ===== src/barometric_compensation_core.sv =====
// Usage:
//   Configuration: write temp_cal, pres_cal_low, pres_cal_high and pres_cal_last
//   through cfg_wr_en/cfg_index/cfg_data while no item is in flight.
//   Input channel in_valid/in_stall carries six raw register bytes per item;
//   output channel out_valid/out_stall returns temperature, pressure and
//   divisor_zero for each item, in order.
//   The pipeline is made up mostly of the 64-stage restoring divider; the
//   rest are multiplier and adder stages.
//   Throughput: one item per cycle while the receiver takes results.
//   Reset clears calibration registers, all valid bits and the output skid.
//   When out_stall holds a valid result, that result moves into a one-entry
//   skid register and in_stall rises on the next cycle; the whole pipeline
//   then holds until the skid is drained. No item is lost or repeated.
// Depends on bcomp_pkg, bcomp_mul and bcomp_div.
module barometric_compensation_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         temp_msb,
	input  logic [7:0]         temp_lsb,
	input  logic [7:0]         temp_xlsb,
	input  logic [7:0]         pres_msb,
	input  logic [7:0]         pres_lsb,
	input  logic [7:0]         pres_xlsb,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] temperature,
	output logic [24:0]        pressure,
	output logic               divisor_zero
);

	logic [47:0] temp_cal_q;
	logic [63:0] pres_cal_low_q;
	logic [63:0] pres_cal_high_q;
	logic [15:0] pres_cal_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q <= '0;
			pres_cal_low_q <= '0;
			pres_cal_high_q <= '0;
			pres_cal_last_q <= '0;
		end else if (cfg_wr_en) begin
			case (bcomp_pkg::cfg_index_t'(cfg_index))
				bcomp_pkg::CfgTempCal: temp_cal_q <= cfg_data[47:0];
				bcomp_pkg::CfgPresCalLow: pres_cal_low_q <= cfg_data;
				bcomp_pkg::CfgPresCalHigh: pres_cal_high_q <= cfg_data;
				bcomp_pkg::CfgPresCalLast: pres_cal_last_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	logic [15:0] t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1 = temp_cal_q[15:0];
	assign t2 = $signed(temp_cal_q[31:16]);
	assign t3 = $signed(temp_cal_q[47:32]);
	assign p1 = pres_cal_low_q[15:0];
	assign p2 = $signed(pres_cal_low_q[31:16]);
	assign p3 = $signed(pres_cal_low_q[47:32]);
	assign p4 = $signed(pres_cal_low_q[63:48]);
	assign p5 = $signed(pres_cal_high_q[15:0]);
	assign p6 = $signed(pres_cal_high_q[31:16]);
	assign p7 = $signed(pres_cal_high_q[47:32]);
	assign p8 = $signed(pres_cal_high_q[63:48]);
	assign p9 = $signed(pres_cal_last_q);

	logic skid_q;
	logic en;

	assign en = !skid_q;
	assign in_stall = skid_q;

	// front end: raw assembly, fine temperature, divisor and numerator
	logic [19:0]        rt;
	logic [19:0]        rp_s [1:8];
	logic signed [15:0] temp_s [5:11];
	logic signed [17:0] ta_s1;
	logic signed [16:0] td_s1;
	logic signed [33:0] tam_s2;
	logic signed [33:0] tdd_s2;
	logic signed [22:0] tash_s3;
	logic signed [37:0] tbm_s3;
	logic signed [24:0] tf_s4;
	logic signed [25:0] pa_s5;
	logic signed [51:0] aa_s6;
	logic signed [41:0] ap5_s6, ap2_s6, ap5_s7, ap2_s7;
	logic signed [40:0] b6h_s7, b6l_s7, b3h_s7, b3l_s7;
	logic signed [63:0] b_s8, x_s8;
	logic [47:0]        mlo_s9;
	logic [31:0]        mhi_s9;
	logic [63:0]        nn_s9;
	logic [30:0]        dv_s10, dv_s11;
	logic [63:0]        n25_s10, num_s11;
	logic               zero_s11;
	logic               vld_s [1:11];

	logic signed [27:0] tr;
	logic signed [19:0] tv;
	logic signed [15:0] tsat;
	logic signed [63:0] a3;
	logic [20:0]        pp;
	logic [63:0]        prod;

	assign rt = {temp_msb, temp_lsb, temp_xlsb[7:4]};

	always_comb begin
		tr = (28'(tf_s4) <<< 2) + 28'(tf_s4) + 28'sd128;
		tv = tr[27:8];
		if (tv > 20'sd32767) begin
			tsat = 16'sh7FFF;
		end else if (tv < -20'sd32768) begin
			tsat = 16'sh8000;
		end else begin
			tsat = tv[15:0];
		end
		a3 = (64'(b3h_s7) <<< 24) + 64'(b3l_s7);
		pp = 21'(bcomp_pkg::RawPresOffset) - {1'b0, rp_s[8]};
		prod = {16'd0, mlo_s9} + {mhi_s9, 32'd0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ta_s1 <= {1'b0, rt[19:3]} - {1'b0, t1, 1'b0};
			td_s1 <= {1'b0, rt[19:4]} - {1'b0, t1};
			rp_s[1] <= {pres_msb, pres_lsb, pres_xlsb[7:4]};
			for (int k = 1; k < 8; k++) begin
				rp_s[k+1] <= rp_s[k];
			end

			tam_s2 <= ta_s1 * t2;
			tdd_s2 <= td_s1 * td_s1;

			tash_s3 <= tam_s2[33:11];
			tbm_s3 <= $signed(tdd_s2[33:12]) * t3;

			tf_s4 <= 25'(tash_s3) + 25'($signed(tbm_s3[37:14]));

			temp_s[5] <= tsat;
			for (int k = 5; k < 11; k++) begin
				temp_s[k+1] <= temp_s[k];
			end
			pa_s5 <= 26'(tf_s4) - 26'(bcomp_pkg::TFineOffset);

			aa_s6 <= pa_s5 * pa_s5;
			ap5_s6 <= pa_s5 * p5;
			ap2_s6 <= pa_s5 * p2;

			b6h_s7 <= $signed({1'b0, aa_s6[47:24]}) * p6;
			b6l_s7 <= $signed({1'b0, aa_s6[23:0]}) * p6;
			b3h_s7 <= $signed({1'b0, aa_s6[47:24]}) * p3;
			b3l_s7 <= $signed({1'b0, aa_s6[23:0]}) * p3;
			ap5_s7 <= ap5_s6;
			ap2_s7 <= ap2_s6;

			b_s8 <= (64'(b6h_s7) <<< 24) + 64'(b6l_s7) + (64'(ap5_s7) <<< 17)
				+ (64'(p4) <<< 35);
			x_s8 <= (a3 >>> 8) + (64'(ap2_s7) <<< 12) + bcomp_pkg::Bias47;

			mlo_s9 <= {16'd0, x_s8[31:0]} * {32'd0, p1};
			mhi_s9 <= x_s8[63:32] * {16'd0, p1};
			nn_s9 <= {12'd0, pp, 31'd0} - b_s8;

			dv_s10 <= prod[63:33];
			n25_s10 <= (nn_s9 << 4) + (nn_s9 << 3) + nn_s9;

			// times 3125 overall
			num_s11 <= (n25_s10 << 7) - (n25_s10 << 2) + n25_s10;
			dv_s11 <= dv_s10;
			zero_s11 <= dv_s10 == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= 11; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int k = 1; k < 11; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	// divider
	bcomp_pkg::side_t side_in, side_div;
	logic               vld_div;
	logic [63:0]        q_div;

	assign side_in = '{temperature: temp_s[11], zero: zero_s11};

	bcomp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s[11]),
		.num      ($signed(num_s11)),
		.den      ($signed(dv_s11)),
		.side_in  (side_in),
		.out_valid(vld_div),
		.quot     (q_div),
		.side_out (side_div)
	);

	// back end: second and third order pressure terms
	logic signed [63:0] xs;
	logic [63:0]        y9, y8, z;
	logic [63:0]        q_s78, q_s79, q_s80, q_s81;
	logic [63:0]        xs_s78, xs_s79;
	logic [63:0]        y8_s80, y8_s81;
	logic signed [63:0] sum_s82;
	bcomp_pkg::side_t   side_s [78:82];
	logic signed [15:0] temp_s83;
	logic [24:0]        pres_s83;
	logic               zero_s83;
	logic               post_vld_s [78:83];
	logic signed [63:0] r;
	logic [24:0]        pres_n;

	assign xs = $signed(q_div) >>> 13;

	bcomp_mul u_mul_p9 (.clk(clk), .en(en), .a(64'(p9)), .b(xs), .p(y9));
	bcomp_mul u_mul_p8 (.clk(clk), .en(en), .a(64'(p8)), .b(q_div), .p(y8));
	bcomp_mul u_mul_sq (.clk(clk), .en(en), .a(y9), .b(xs_s79), .p(z));

	always_comb begin
		r = (sum_s82 >>> 8) + (64'(p7) <<< 4);
		if (side_s[82].zero || r[63]) begin
			pres_n = '0;
		end else if (|r[62:25]) begin
			pres_n = bcomp_pkg::PresMax;
		end else begin
			pres_n = r[24:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s78 <= q_div;
			q_s79 <= q_s78;
			q_s80 <= q_s79;
			q_s81 <= q_s80;
			xs_s78 <= xs;
			xs_s79 <= xs_s78;
			y8_s80 <= y8;
			y8_s81 <= y8_s80;
			side_s[78] <= side_div;
			for (int k = 78; k < 82; k++) begin
				side_s[k+1] <= side_s[k];
			end
			sum_s82 <= $signed(q_s81) + ($signed(z) >>> 25) + ($signed(y8_s81) >>> 19);
			temp_s83 <= side_s[82].temperature;
			pres_s83 <= pres_n;
			zero_s83 <= side_s[82].zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 78; k <= 83; k++) begin
				post_vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			post_vld_s[78] <= vld_div;
			for (int k = 78; k < 83; k++) begin
				post_vld_s[k+1] <= post_vld_s[k];
			end
		end
	end

	// output skid
	logic signed [15:0] skid_temp_q;
	logic [24:0]        skid_pres_q;
	logic               skid_zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_q <= 1'b0;
		end else if (skid_q) begin
			skid_q <= out_stall;
		end else begin
			skid_q <= post_vld_s[83] && out_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_q) begin
			skid_temp_q <= temp_s83;
			skid_pres_q <= pres_s83;
			skid_zero_q <= zero_s83;
		end
	end

	assign out_valid = skid_q || post_vld_s[83];
	assign temperature = skid_q ? skid_temp_q : temp_s83;
	assign pressure = skid_q ? skid_pres_q : pres_s83;
	assign divisor_zero = skid_q ? skid_zero_q : zero_s83;

	a_skid_capture: assert property (@(posedge clk) disable iff (!arst_n)
		post_vld_s[83] && out_stall && !skid_q |=>
			skid_q && skid_pres_q == $past(pres_s83))
		else $error("stalled result not captured in skid");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q && !out_stall |=> !skid_q)
		else $error("skid not drained after delivery");

	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divisor_zero |-> pressure == '0)
		else $error("pressure nonzero with zero divisor");

endmodule

// ===== src/bcomp_mul.sv =====
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
// Built from 32x32 partial products; no package dependencies.
module bcomp_mul (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);

	logic [63:0] ll_s1;
	logic [31:0] hl_s1;
	logic [31:0] lh_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
			hl_s1 <= a[63:32] * b[31:0];
			lh_s1 <= a[31:0] * b[63:32];
			p <= ll_s1 + {hl_s1 + lh_s1, 32'd0};
		end
	end

endmodule

// ===== src/bcomp_div.sv =====
// Pipelined signed 64/31-bit divider, one restoring step per stage, truncating.
// Uses bcomp_pkg for the step count, divisor width and sideband type.
module bcomp_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [63:0]       num,
	input  logic signed [30:0]       den,
	input  bcomp_pkg::side_t         side_in,
	output logic                     out_valid,
	output logic [63:0]              quot,
	output bcomp_pkg::side_t         side_out
);

	localparam int Steps = bcomp_pkg::DivSteps;
	localparam int DW = bcomp_pkg::DenW;

	logic                   vld_s  [0:Steps];
	logic [63:0]            num_s  [0:Steps];
	logic [DW-1:0]          rem_s  [0:Steps];
	logic [DW-1:0]          den_s  [0:Steps];
	logic                   neg_s  [0:Steps];
	bcomp_pkg::side_t       side_s [0:Steps];

	logic [DW:0]            trial  [0:Steps-1];
	logic [DW:0]            diff   [0:Steps-1];
	logic                   ge     [0:Steps-1];
	logic [DW-1:0]          rem_n  [0:Steps-1];
	logic [63:0]            num_n  [0:Steps-1];

	always_comb begin
		for (int k = 0; k < Steps; k++) begin
			trial[k] = {rem_s[k], num_s[k][63]};
			diff[k] = trial[k] - {1'b0, den_s[k]};
			ge[k] = trial[k] >= {1'b0, den_s[k]};
			rem_n[k] = ge[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
			num_n[k] = {num_s[k][62:0], ge[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= Steps; k++) begin
				vld_s[k] <= 1'b0;
			end
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 0; k < Steps; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
			out_valid <= vld_s[Steps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0] <= num[63] ? -num : num;
			den_s[0] <= den[DW-1] ? -den : den;
			neg_s[0] <= num[63] ^ den[DW-1];
			rem_s[0] <= '0;
			side_s[0] <= side_in;
			for (int k = 0; k < Steps; k++) begin
				num_s[k+1] <= num_n[k];
				rem_s[k+1] <= rem_n[k];
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				side_s[k+1] <= side_s[k];
			end
			quot <= neg_s[Steps] ? -num_s[Steps] : num_s[Steps];
			side_out <= side_s[Steps];
		end
	end

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[Steps] && den_s[Steps] != '0 |-> rem_s[Steps] < den_s[Steps])
		else $error("divider remainder not below divisor");

	a_out_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(vld_s[Steps]))
		else $error("divider output valid without last stage");

	a_den_zero_side: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] && !side_s[0].zero |-> den_s[0] != '0)
		else $error("nonzero divisor lost in abs stage");

endmodule
